@@ rtl/rel_pkg.sv @@
`default_nettype none

package rel_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// default delay memory depth
	localparam int DELAY_DEPTH_DEF = 65536;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_START    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_DECAY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_THRESH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_COUNT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_FROM   = 3'd6;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_POS,
		ST_MIX,
		ST_SCALE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ rtl/rel_ram.sv @@
`default_nettype none

module rel_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/reversible_echo_with_limiter.sv @@
`default_nettype none

// channel   dir  tdata                                   tuser
// s_axis    in   [15:0] sample_in                        [0] direction
// m_axis    out  [15:0] sample_out, [31:16] limiter_level  -
// cfg       in   cfg_data[15:0] to register cfg_index     -
//
// One item at a time, each through these steps: accept, position update with the delay read
// (or the clear write), mix multiply, limiter multiply, write-back; the result beat is
// registered at write-back. One memory port and two chained multiplies set these steps.
// After reset a clearing pass writes zero to every delay memory address, with
// s_axis_tready low; configuration writes are taken during it.
// A waiting result does not block input; the next item holds in write-back until it leaves.

module reversible_echo_with_limiter #(
	parameter int DELAY_DEPTH = rel_pkg::DELAY_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
	input  wire logic [0:0]  s_axis_tuser,   // [0] direction

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [15:0] sample_out, [31:16] limiter_level

	input  wire logic                           cfg_we,
	input  wire logic [rel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rel_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int PW = rel_pkg::POS_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
	localparam logic signed [20:0] SAT_HI = 21'sd32767;
	localparam logic signed [20:0] SAT_LO = -21'sd32768;
	localparam logic signed [50:0] ROUND_NEG = 51'sd1073741823;

	// configuration registers
	logic [PW-1:0]                  loop_length_q;
	logic [rel_pkg::GAIN_W-1:0]     echo_gain_q;
	logic [rel_pkg::GAIN_W-1:0]     lim_decay_q;
	logic [rel_pkg::THR_W-1:0]      lim_thresh_q;

	// live state
	logic [PW-1:0]                  wp_q;
	logic [15:0]                    lim_gain_q;
	logic [15:0]                    clr_rem_q;
	logic [PW-1:0]                  clr_wait_q;

	rel_pkg::state_t state_q, state_d;
	logic [AW-1:0] init_cnt_q;

	// item datapath
	logic signed [15:0] sample_q;
	logic               dir_q;
	logic               use_delay_q;
	logic signed [33:0] mix_q;
	logic signed [50:0] prod_q;
	logic [31:0]        decay_prod_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic [15:0] out_level_q;

	// ram port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_wdata;
	logic [15:0]   ram_rdata;

	logic in_fire;
	logic done_fire;

	rel_ram #(
		.WIDTH (rel_pkg::SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// effective loop length, capped at the memory depth
	logic [PW-1:0] len;
	always_comb begin
		if ({2'b00, loop_length_q} > 18'(DELAY_DEPTH)) begin
			len = PW'(DELAY_DEPTH);
		end else begin
			len = loop_length_q;
		end
	end

	// position update for the step in progress
	logic          bypass;
	logic [PW:0]   wp_inc;
	logic [PW-1:0] wp_fwd;
	logic [PW:0]   wp_fwd_inc;
	logic [PW-1:0] rd_fwd;
	logic [PW-1:0] wp_bwd;
	logic [PW-1:0] rd_bwd;
	logic [PW-1:0] wp_new;
	logic [PW-1:0] rd_pos;
	logic [PW-1:0] clr_wait_new;
	logic          do_clear;
	always_comb begin
		bypass     = (len == '0);
		wp_inc     = {1'b0, wp_q} + 1'b1;
		wp_fwd     = (wp_inc >= {1'b0, len}) ? '0 : wp_inc[PW-1:0];
		wp_fwd_inc = {1'b0, wp_fwd} + 1'b1;
		rd_fwd     = (wp_fwd_inc >= {1'b0, len}) ? '0 : wp_fwd_inc[PW-1:0];
		wp_bwd     = (wp_q == '0 || wp_q >= len) ? len - 1'b1 : wp_q - 1'b1;
		rd_bwd     = (wp_bwd == '0) ? len - 1'b1 : wp_bwd - 1'b1;
		wp_new       = wp_q;
		rd_pos       = '0;
		clr_wait_new = clr_wait_q;
		do_clear     = 1'b0;
		if (!bypass) begin
			if (dir_q) begin
				wp_new = wp_fwd;
				rd_pos = rd_fwd;
				if (clr_rem_q != '0) begin
					if (clr_wait_q != '0 && clr_wait_q == rd_fwd) begin
						clr_wait_new = '0;
					end
					do_clear = (clr_wait_new == '0);
				end
			end else begin
				wp_new = wp_bwd;
				rd_pos = rd_bwd;
			end
		end
	end

	// mix of input and scaled delayed sample
	logic signed [16:0] delayed;
	logic signed [33:0] fb_term;
	logic signed [33:0] mix_d;
	always_comb begin
		delayed = use_delay_q ? 17'(signed'(ram_rdata)) : '0;
		fb_term = delayed * signed'({1'b0, echo_gain_q});
		mix_d   = 34'(sample_q) * 34'sd32768 + fb_term;
	end

	// limiter, truncation toward zero and saturation
	logic signed [50:0] thr_neg;
	logic               overload;
	logic signed [50:0] prod_adj;
	logic signed [20:0] quot;
	logic [15:0]        result;
	logic [15:0]        lim_gain_new;
	always_comb begin
		thr_neg  = -$signed({6'd0, lim_thresh_q, 30'd0});
		overload = (prod_q < thr_neg) && (lim_gain_q != '0);
		prod_adj = prod_q + (prod_q[50] ? ROUND_NEG : 51'sd0);
		quot     = 21'(prod_adj >>> 30);
		if (quot > SAT_HI) begin
			result = SAT_HI[15:0];
		end else if (quot < SAT_LO) begin
			result = SAT_LO[15:0];
		end else begin
			result = quot[15:0];
		end
		lim_gain_new = overload ? decay_prod_q[31:16] : lim_gain_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rel_pkg::ST_INIT: begin
				if (init_cnt_q == LAST_ADDR) state_d = rel_pkg::ST_IDLE;
			end
			rel_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_d = rel_pkg::ST_POS;
			end
			rel_pkg::ST_POS:   state_d = rel_pkg::ST_MIX;
			rel_pkg::ST_MIX:   state_d = rel_pkg::ST_SCALE;
			rel_pkg::ST_SCALE: state_d = rel_pkg::ST_DONE;
			rel_pkg::ST_DONE: begin
				if (!out_valid_q || m_axis_tready) state_d = rel_pkg::ST_IDLE;
			end
			default: state_d = rel_pkg::ST_INIT;
		endcase
	end

	// state outputs and memory port
	always_comb begin
		s_axis_tready = 1'b0;
		done_fire     = 1'b0;
		ram_we        = 1'b0;
		ram_addr      = '0;
		ram_wdata     = '0;
		case (state_q)
			rel_pkg::ST_INIT: begin
				ram_we   = 1'b1;
				ram_addr = init_cnt_q;
			end
			rel_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			rel_pkg::ST_POS: begin
				ram_we   = do_clear;
				ram_addr = AW'(rd_pos);
			end
			rel_pkg::ST_DONE: begin
				done_fire = !out_valid_q || m_axis_tready;
				ram_we    = done_fire;
				ram_addr  = AW'(wp_q);
				ram_wdata = result;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rel_pkg::ST_INIT;
			init_cnt_q    <= '0;
			loop_length_q <= 16'd33075;
			echo_gain_q   <= 16'd16384;
			lim_decay_q   <= 16'd64880;
			lim_thresh_q  <= 15'd30000;
			wp_q          <= '0;
			lim_gain_q    <= 16'd32768;
			clr_rem_q     <= '0;
			clr_wait_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rel_pkg::ST_INIT) begin
				init_cnt_q <= init_cnt_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					rel_pkg::REG_LOOP_LENGTH: loop_length_q <= cfg_data;
					rel_pkg::REG_ECHO_GAIN:   echo_gain_q   <= cfg_data;
					rel_pkg::REG_LIM_START:   lim_gain_q    <= cfg_data;
					rel_pkg::REG_LIM_DECAY:   lim_decay_q   <= cfg_data;
					rel_pkg::REG_LIM_THRESH:  lim_thresh_q  <= cfg_data[rel_pkg::THR_W-1:0];
					rel_pkg::REG_CLEAR_COUNT: clr_rem_q     <= cfg_data;
					rel_pkg::REG_CLEAR_FROM:  clr_wait_q    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == rel_pkg::ST_POS) begin
				wp_q       <= wp_new;
				clr_wait_q <= clr_wait_new;
				if (do_clear) clr_rem_q <= clr_rem_q - 1'b1;
			end
			if (done_fire) begin
				lim_gain_q  <= lim_gain_new;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload through the steps
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= signed'(s_axis_tdata);
			dir_q    <= s_axis_tuser[0];
		end
		if (state_q == rel_pkg::ST_POS) begin
			use_delay_q <= !bypass && !do_clear;
		end
		if (state_q == rel_pkg::ST_MIX) begin
			mix_q <= mix_d;
		end
		if (state_q == rel_pkg::ST_SCALE) begin
			prod_q       <= mix_q * signed'({1'b0, lim_gain_q});
			decay_prod_q <= lim_gain_q * lim_decay_q;
		end
		if (done_fire) begin
			out_sample_q <= result;
			out_level_q  <= lim_gain_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_level_q, out_sample_q};

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam bit DIR_FWD = 1'b1;
	localparam bit DIR_BWD = 1'b0;
	localparam int MEM_DEPTH = rel_pkg::DELAY_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1400;

	typedef struct {
		logic signed [15:0] sample;
		logic [15:0]        level;
	} echo_beat_t;

	typedef enum {RX_OPEN, RX_CADENCE, RX_COIN, RX_CHOKE} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [15:0] sample_in
	logic [0:0]  s_axis_tuser;   // [0] direction
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [15:0] sample_out, [31:16] limiter_level
	logic                           cfg_we;
	logic [rel_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rel_pkg::CFG_DATA_W-1:0] cfg_data;

	reversible_echo_with_limiter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// echo state mirror
	logic signed [15:0] delay_mem [0:MEM_DEPTH-1];
	int unsigned loop_len_r, echo_gain_r, lim_decay_r, lim_thresh_r;
	int unsigned wr_pos, lim_now, clr_left, clr_wait;

	echo_beat_t echo_due[$];
	echo_beat_t head;
	int mismatches, beats_checked, samples_sent, cfg_writes, phases;

	// sender and receiver pacing
	int burst_left;
	bit fwd_now;
	int dir_left;
	rx_mode_t rx_mode;
	int rx_mode_left, rx_hold, rx_tick;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one echo step: move, optionally clear, mix, limit, write back
	function automatic echo_beat_t echo_advance(input logic signed [15:0] smp, input bit fwd);
		int unsigned len, rd;
		longint mixv, prod, res;
		echo_beat_t r;
		len = loop_len_r;
		mixv = longint'(smp) * 32768;
		if (len != 0) begin
			if (fwd) begin
				wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
				rd = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
				if (clr_left != 0) begin
					if (clr_wait != 0 && clr_wait == rd)
						clr_wait = 0;
					if (clr_wait == 0) begin
						delay_mem[rd] = '0;
						clr_left = (clr_left - 1) & 16'hFFFF;
					end
				end
			end else begin
				wr_pos = (wr_pos == 0 || wr_pos >= len) ? len - 1 : wr_pos - 1;
				rd = (wr_pos == 0) ? len - 1 : wr_pos - 1;
			end
			mixv += longint'(delay_mem[rd]) * longint'(echo_gain_r);
		end
		prod = mixv * longint'(lim_now);
		// overload pulls the limiter level down
		if (prod < -(longint'(lim_thresh_r) * 1073741824) && lim_now > 0)
			lim_now = int'((longint'(lim_now) * longint'(lim_decay_r)) >>> 16) & 16'hFFFF;
		// truncate toward zero, then saturate
		if (prod < 0)
			res = -((-prod) >>> 30);
		else
			res = prod >>> 30;
		if (res > 32767)
			res = 32767;
		if (res < -32768)
			res = -32768;
		r.sample = res[15:0];
		r.level = lim_now[15:0];
		delay_mem[wr_pos] = r.sample;
		return r;
	endfunction

	function automatic int pick_edge(input int lo, input int hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
			3, 4: return 16'($urandom_range(0, 511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// register write, mirrored into the echo state
	task automatic set_reg(input logic [rel_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
		cfg_writes++;
		case (idx)
			rel_pkg::REG_LOOP_LENGTH: loop_len_r = val & 16'hFFFF;
			rel_pkg::REG_ECHO_GAIN:   echo_gain_r = val & 16'hFFFF;
			rel_pkg::REG_LIM_START:   lim_now = val & 16'hFFFF;
			rel_pkg::REG_LIM_DECAY:   lim_decay_r = val & 16'hFFFF;
			rel_pkg::REG_LIM_THRESH:  lim_thresh_r = val & 16'h7FFF;
			rel_pkg::REG_CLEAR_COUNT: clr_left = val & 16'hFFFF;
			rel_pkg::REG_CLEAR_FROM:  clr_wait = val & 16'hFFFF;
			default: ;
		endcase
	endtask

	// one sample beat; bursts with random gaps in front of each burst
	task automatic send_sample(input logic signed [15:0] smp, input bit fwd);
		int gap;
		cfg_we <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= fwd;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		echo_due.push_back(echo_advance(smp, fwd));
		samples_sent++;
	endtask

	// let every result come out, then give the pipeline time to settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (echo_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// result checker, sampled mid-cycle so the beat is stable
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (echo_due.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				head = echo_due.pop_front();
				if (m_axis_tdata[15:0] !== head.sample) begin
					$display("%0t: sample_out expected %0d actual %0d", $time,
						head.sample, $signed(m_axis_tdata[15:0]));
					mismatches++;
				end
				if (m_axis_tdata[31:16] !== head.level) begin
					$display("%0t: limiter_level expected %0d actual %0d", $time,
						head.level, m_axis_tdata[31:16]);
					mismatches++;
				end
				beats_checked++;
			end
		end
	end

	// receiver stalls, switching between a few styles
	always @(posedge clk) begin
		rx_tick++;
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(50, 300);
		end
		rx_mode_left--;
		case (rx_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_CADENCE: m_axis_tready <= (rx_tick % 5) < 3;
			RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
			default: begin
				if (rx_hold != 0) begin
					rx_hold--;
					m_axis_tready <= 1'b0;
				end else begin
					rx_hold = $urandom_range(1, 15);
					m_axis_tready <= 1'b1;
				end
			end
		endcase
	end

	// reset values of the registers, extremes of the sample
	task automatic test_default_regs();
		send_sample(16'sh7FFF, DIR_FWD);
		send_sample(16'sh8000, DIR_BWD);
		send_sample(-16'sd1, DIR_BWD);
		send_sample(16'sd0, DIR_FWD);
	endtask

	// loop off, limiter collapse and threshold masking
	task automatic test_bypass_limiter();
		drain();
		set_reg(rel_pkg::REG_LOOP_LENGTH, 0);
		set_reg(rel_pkg::REG_ECHO_GAIN, 65535);
		set_reg(rel_pkg::REG_LIM_START, 32768);
		set_reg(rel_pkg::REG_LIM_DECAY, 0);
		set_reg(rel_pkg::REG_LIM_THRESH, 0);
		send_sample(16'sh8000, DIR_FWD);
		send_sample(16'sh7FFF, DIR_BWD);
		drain();
		set_reg(rel_pkg::REG_LIM_START, 32768);
		set_reg(rel_pkg::REG_LIM_DECAY, 65535);
		set_reg(rel_pkg::REG_LIM_THRESH, 16'hFFFF);
		send_sample(16'sh8000, DIR_FWD);
		send_sample(16'sh8000, DIR_BWD);
		send_sample(16'sh7FFF, DIR_FWD);
	endtask

	// saturation through feedback, wrap in both directions, shrinking loop
	task automatic test_wrap_saturate();
		drain();
		set_reg(rel_pkg::REG_LOOP_LENGTH, 1);
		set_reg(rel_pkg::REG_LIM_START, 32768);
		set_reg(rel_pkg::REG_LIM_THRESH, 32767);
		send_sample(16'sh7FFF, DIR_FWD);
		send_sample(16'sh7FFF, DIR_FWD);
		send_sample(16'sh8000, DIR_BWD);
		send_sample(16'sh8000, DIR_BWD);
		drain();
		set_reg(rel_pkg::REG_LOOP_LENGTH, 65535);
		send_sample(16'sd1000, DIR_BWD);
		drain();
		set_reg(rel_pkg::REG_LOOP_LENGTH, 40);
		send_sample(16'sd2000, DIR_FWD);
		drain();
		set_reg(rel_pkg::REG_LOOP_LENGTH, 65535);
		send_sample(-16'sd3000, DIR_BWD);
		send_sample(16'sd4000, DIR_FWD);
		drain();
		set_reg(rel_pkg::REG_LOOP_LENGTH, 40);
		send_sample(-16'sd5000, DIR_BWD);
	endtask

	// delayed clear start, immediate clear, no clearing on backward steps
	task automatic test_clear();
		drain();
		set_reg(rel_pkg::REG_LOOP_LENGTH, 6);
		set_reg(rel_pkg::REG_ECHO_GAIN, 32768);
		for (int i = 0; i < 4; i++)
			send_sample(16'(1111 * (i + 1)), DIR_FWD);
		drain();
		set_reg(rel_pkg::REG_CLEAR_FROM, 4);
		set_reg(rel_pkg::REG_CLEAR_COUNT, 3);
		for (int i = 0; i < 4; i++)
			send_sample(16'sd7, DIR_FWD);
		drain();
		set_reg(rel_pkg::REG_CLEAR_FROM, 0);
		set_reg(rel_pkg::REG_CLEAR_COUNT, 65535);
		send_sample(16'sd9, DIR_FWD);
		send_sample(16'sd9, DIR_BWD);
		send_sample(16'sd9, DIR_FWD);
	endtask

	// random settings per phase, direction runs with random content
	task automatic test_random_phases(input int target);
		int len, n, done;
		done = 0;
		while (done < target) begin
			drain();
			phases++;
			case ($urandom_range(0, 9))
				0: len = 0;
				1: len = pick_edge(1024, 65535);
				2, 3: len = $urandom_range(33, 1024);
				default: len = $urandom_range(1, 32);
			endcase
			set_reg(rel_pkg::REG_LOOP_LENGTH, len);
			if ($urandom_range(0, 1))
				set_reg(rel_pkg::REG_ECHO_GAIN, pick_edge(0, 65535));
			if ($urandom_range(0, 2) != 0)
				set_reg(rel_pkg::REG_LIM_START, pick_edge(0, 32768));
			if ($urandom_range(0, 1))
				set_reg(rel_pkg::REG_LIM_DECAY, pick_edge(0, 65535));
			if ($urandom_range(0, 1))
				set_reg(rel_pkg::REG_LIM_THRESH, ($urandom_range(0, 1) ?
					pick_edge(16384, 32767) : pick_edge(0, 32767)) |
					($urandom_range(0, 3) == 0 ? 32'h8000 : 0));
			if ($urandom_range(0, 2) == 0)
				set_reg(rel_pkg::REG_CLEAR_FROM, ($urandom_range(0, 5) == 0) ? 65535 :
					pick_edge(0, (len < 65534) ? len + 1 : 65535));
			if ($urandom_range(0, 2) == 0)
				set_reg(rel_pkg::REG_CLEAR_COUNT, ($urandom_range(0, 5) == 0) ? 65535 :
					$urandom_range(0, (len < 32000) ? 2 * len + 2 : 65535));
			n = $urandom_range(30, 150);
			for (int i = 0; i < n; i++) begin
				if (dir_left == 0) begin
					fwd_now = $urandom_range(0, 1);
					dir_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 30);
				end
				dir_left--;
				send_sample(pick_sample(), fwd_now);
			end
			done += n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		foreach (delay_mem[i])
			delay_mem[i] = '0;
		loop_len_r = 33075;
		echo_gain_r = 16384;
		lim_now = 32768;
		lim_decay_r = 64880;
		lim_thresh_r = 30000;
		clr_left = 0;
		clr_wait = 0;
		wr_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_default_regs();
		test_bypass_limiter();
		test_wrap_saturate();
		test_clear();
		test_random_phases(RANDOM_ITEMS);
		drain();

		$display("%0d samples sent across %0d random phases, %0d register writes",
			samples_sent, phases, cfg_writes);
		$display("%0d results compared, %0d field mismatches", beats_checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", echo_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rel_pkg.sv
rtl/rel_ram.sv
rtl/reversible_echo_with_limiter.sv
tb/sv/tb.sv
